[rtl/core/bpa_pkg.sv]
package bpa_pkg;

   // fixed field widths
   localparam int ADDR_W = 32;
   localparam int CNT_W = 13;
   localparam int KIND_W = 2;
   localparam int STATUS_W = 3;
   localparam int CSR_INDEX_W = 1;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_PHYS_BASE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAGE_COUNT = 1'b1;

   localparam logic [CNT_W-1:0] PAGE_COUNT_RESET = 13'd4096;

   // request kinds; the remaining code is a no-op
   typedef enum logic [KIND_W-1:0] {
      KIND_ALLOC = 2'd0,
      KIND_FREE = 2'd1,
      KIND_RESERVE = 2'd2
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK = 3'd0,
      STAT_OUT_OF_MEMORY = 3'd1,
      STAT_OUT_OF_RANGE = 3'd2,
      STAT_MISALIGNED = 3'd3,
      STAT_ALREADY_FREE = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_PREP,
      S_SETUP,
      S_START,
      S_SWEEP,
      S_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic clear;
      logic load_item;
      logic prep;
      logic setup;
      logic sweep_start;
      logic resp_load;
   } bpa_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic need_sweep;
      logic sweep_idle;
      logic out_free;
   } bpa_stat_type;

endpackage

[rtl/core/bpa_ram.sv]
module bpa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/bpa_ctrl.sv]
module bpa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  bpa_pkg::bpa_stat_type stat,
   output bpa_pkg::bpa_cmd_type  cmd
);

   import bpa_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_SETUP;
         end
         S_SETUP: begin
            cmd.setup = 1'b1;
            state_in = S_START;
         end
         S_START: begin
            if (stat.need_sweep) begin
               cmd.sweep_start = 1'b1;
               state_in = S_SWEEP;
            end else begin
               state_in = S_RESP;
            end
         end
         S_SWEEP: begin
            if (stat.sweep_idle) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (stat.out_free) begin
               cmd.resp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

endmodule

[rtl/core/bpa_datapath.sv]
module bpa_datapath #(
   parameter int MAX_PAGES = 4096,
   parameter int PAGE_BYTES = 4096,
   parameter int WORD_BITS = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration
   input  logic                                  csr_we,
   input  logic [bpa_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [bpa_pkg::ADDR_W-1:0]            csr_wdata,
   // request payload
   input  logic [63:0]                           req_tdata,
   input  logic [bpa_pkg::KIND_W-1:0]            req_tuser,
   // control
   input  bpa_pkg::bpa_cmd_type                  cmd,
   output bpa_pkg::bpa_stat_type                 stat,
   // response
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [63:0]                           rsp_tdata
);

   import bpa_pkg::*;

   localparam int WORD_COUNT = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int WADDR_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int BIT_W = $clog2(WORD_BITS);
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int NCHUNK = WORD_BITS / 8;
   localparam int POP_W = $clog2(WORD_BITS + 1);
   localparam logic [ADDR_W-1:0] PAGE_MASK = ADDR_W'(PAGE_BYTES - 1);

   // configuration and derived RAM window
   logic [ADDR_W-1:0] phys_base_ff;
   logic [CNT_W-1:0]  page_count_ff;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [CNT_W-1:0]  pc_ff, pc_in;
   logic [ADDR_W:0]   ram_end_ff, ram_end_in;

   // transaction fields
   logic [ADDR_W-1:0] addr_ff;
   logic [ADDR_W-1:0] end_ff;
   kind_type          kind_ff;

   // check stage
   logic              range_err_ff, range_err_in;
   logic              align_err_ff, align_err_in;
   logic [CNT_W-1:0]  free_idx_ff, free_idx_in;
   logic              nonempty_ff, nonempty_in;
   logic [ADDR_W:0]   s_clamp_ff, s_clamp_in;
   logic [ADDR_W:0]   e_clamp_ff, e_clamp_in;
   logic [ADDR_W-1:0] free_diff;
   logic [ADDR_W:0]   s_align, e_align;

   // sweep bounds
   logic               need_ff, need_in;
   logic [WADDR_W-1:0] first_word_ff, first_word_in;
   logic [WADDR_W-1:0] last_word_ff, last_word_in;
   logic [BIT_W-1:0]   first_bit_ff, first_bit_in;
   logic [BIT_W-1:0]   last_bit_ff, last_bit_in;
   logic [CNT_W-1:0]   first_pg, last_pg;
   logic [ADDR_W:0]    s_off, e_off;
   logic [31:0]        first_pg32, last_pg32;

   // sweep engine
   logic               issuing_ff, issuing_in;
   logic [WADDR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic               chk_valid_ff, chk_valid_in;
   logic [WADDR_W-1:0] chk_word_ff;
   logic [WORD_BITS-1:0] ram_rd_data;
   logic [BIT_W-1:0]   lo_b, hi_b;
   logic [WORD_BITS-1:0] word_mask, cand, lowest, new_word, newbits;
   logic               alloc_hit, free_hit, free_miss;
   logic [BIT_W-1:0]   hit_bit;
   logic [31:0]        hit_page32;

   // popcount stage for reserve
   logic               pop_valid_ff, pop_valid_in;
   logic [3:0]         chunk_cnt_ff [NCHUNK];
   logic [3:0]         chunk_cnt_in [NCHUNK];
   logic [POP_W-1:0]   pop_sum;

   // result state
   logic [CNT_W-1:0]   used_ff, used_in;
   status_type         status_ff, status_in;
   logic               found_ff, found_in;
   logic [CNT_W-1:0]   alloc_idx_ff;

   // clearing pass and RAM port
   logic [WADDR_W-1:0] clr_ptr_ff;
   logic               ram_we;
   logic [WADDR_W-1:0] ram_waddr;
   logic [WORD_BITS-1:0] ram_wdata;

   // output register
   logic               rsp_tvalid_ff;
   logic [63:0]        rsp_tdata_ff, rsp_tdata_in;
   logic [ADDR_W-1:0]  out_addr;
   logic [CNT_W-1:0]   out_free;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         phys_base_ff <= '0;
         page_count_ff <= PAGE_COUNT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PHYS_BASE: phys_base_ff <= csr_wdata;
            CSR_PAGE_COUNT: page_count_ff <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // aligned base, effective page count and end of RAM
   always_comb begin
      base_in = phys_base_ff & ~PAGE_MASK;
      pc_in = (32'(page_count_ff) > 32'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : page_count_ff;
      ram_end_in = {1'b0, base_in} + ((ADDR_W + 1)'(pc_in) << PAGE_SHIFT);
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      pc_ff <= pc_in;
      ram_end_ff <= ram_end_in;
   end

   // capture the transaction
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         addr_ff <= req_tdata[31:0];
         end_ff <= req_tdata[63:32];
         kind_ff <= kind_type'(req_tuser);
      end
   end

   // range and alignment checks, reserve range clamping
   always_comb begin
      range_err_in = (addr_ff < base_ff) || ({1'b0, addr_ff} >= ram_end_ff);
      align_err_in = |(addr_ff & PAGE_MASK);
      free_diff = addr_ff - base_ff;
      free_idx_in = free_diff[PAGE_SHIFT +: CNT_W];
      nonempty_in = end_ff > addr_ff;
      s_align = {1'b0, addr_ff & ~PAGE_MASK};
      e_align = ({1'b0, end_ff} + (ADDR_W + 1)'(PAGE_BYTES - 1)) & ~{1'b0, PAGE_MASK};
      s_clamp_in = (s_align < {1'b0, base_ff}) ? {1'b0, base_ff} : s_align;
      e_clamp_in = (e_align > ram_end_ff) ? ram_end_ff : e_align;
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         range_err_ff <= range_err_in;
         align_err_ff <= align_err_in;
         free_idx_ff <= free_idx_in;
         nonempty_ff <= nonempty_in;
         s_clamp_ff <= s_clamp_in;
         e_clamp_ff <= e_clamp_in;
      end
   end

   // page span and sweep need per kind
   always_comb begin
      s_off = s_clamp_ff - {1'b0, base_ff};
      e_off = e_clamp_ff - {1'b0, base_ff};
      need_in = 1'b0;
      first_pg = '0;
      last_pg = '0;
      case (kind_ff)
         KIND_ALLOC: begin
            need_in = pc_ff != '0;
            last_pg = pc_ff - CNT_W'(1);
         end
         KIND_FREE: begin
            need_in = !range_err_ff && !align_err_ff;
            first_pg = free_idx_ff;
            last_pg = free_idx_ff;
         end
         KIND_RESERVE: begin
            need_in = nonempty_ff && (e_clamp_ff > s_clamp_ff);
            first_pg = s_off[PAGE_SHIFT +: CNT_W];
            last_pg = e_off[PAGE_SHIFT +: CNT_W] - CNT_W'(1);
         end
         default: ;
      endcase
      first_pg32 = 32'(first_pg);
      last_pg32 = 32'(last_pg);
      first_word_in = first_pg32[BIT_W +: WADDR_W];
      last_word_in = last_pg32[BIT_W +: WADDR_W];
      first_bit_in = first_pg[BIT_W-1:0];
      last_bit_in = last_pg[BIT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         need_ff <= need_in;
         first_word_ff <= first_word_in;
         last_word_ff <= last_word_in;
         first_bit_ff <= first_bit_in;
         last_bit_ff <= last_bit_in;
      end
   end

   // word processing: mask of pages in span, then per kind update
   always_comb begin
      lo_b = (chk_word_ff == first_word_ff) ? first_bit_ff : '0;
      hi_b = (chk_word_ff == last_word_ff) ? last_bit_ff : BIT_W'(WORD_BITS - 1);
      for (int b = 0; b < WORD_BITS; b++) begin
         word_mask[b] = (BIT_W'(b) >= lo_b) && (BIT_W'(b) <= hi_b);
      end
      cand = ~ram_rd_data & word_mask;
      lowest = cand & (~cand + WORD_BITS'(1));
      hit_bit = '0;
      for (int b = 0; b < WORD_BITS; b++) begin
         if (lowest[b]) begin
            hit_bit = hit_bit | BIT_W'(b);
         end
      end
      hit_page32 = (32'(chk_word_ff) << BIT_W) | 32'(hit_bit);
      newbits = word_mask & ~ram_rd_data;
      alloc_hit = chk_valid_ff && (kind_ff == KIND_ALLOC) && (|cand);
      free_hit = chk_valid_ff && (kind_ff == KIND_FREE) && (|(ram_rd_data & word_mask));
      free_miss = chk_valid_ff && (kind_ff == KIND_FREE) && !(|(ram_rd_data & word_mask));
      case (kind_ff)
         KIND_ALLOC: new_word = ram_rd_data | lowest;
         KIND_FREE: new_word = ram_rd_data & ~word_mask;
         KIND_RESERVE: new_word = ram_rd_data | word_mask;
         default: new_word = ram_rd_data;
      endcase
   end

   // read issue: one word a cycle, stopped by an allocation hit or after the last word
   always_comb begin
      issuing_in = issuing_ff;
      rd_ptr_in = rd_ptr_ff;
      chk_valid_in = issuing_ff && !alloc_hit;
      if (cmd.sweep_start) begin
         issuing_in = 1'b1;
         rd_ptr_in = first_word_ff;
      end else if (issuing_ff) begin
         if (alloc_hit || (rd_ptr_ff == last_word_ff)) begin
            issuing_in = 1'b0;
         end else begin
            rd_ptr_in = rd_ptr_ff + WADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issuing_ff <= 1'b0;
         chk_valid_ff <= 1'b0;
      end else begin
         issuing_ff <= issuing_in;
         chk_valid_ff <= chk_valid_in;
      end
      rd_ptr_ff <= rd_ptr_in;
      chk_word_ff <= rd_ptr_ff;
   end

   // popcount of newly set bits, byte chunks first
   always_comb begin
      pop_valid_in = chk_valid_ff && (kind_ff == KIND_RESERVE);
      for (int c = 0; c < NCHUNK; c++) begin
         chunk_cnt_in[c] = '0;
         for (int k = 0; k < 8; k++) begin
            chunk_cnt_in[c] = chunk_cnt_in[c] + 4'(newbits[c * 8 + k]);
         end
      end
      pop_sum = '0;
      for (int c = 0; c < NCHUNK; c++) begin
         pop_sum = pop_sum + POP_W'(chunk_cnt_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pop_valid_ff <= 1'b0;
      end else begin
         pop_valid_ff <= pop_valid_in;
      end
      chunk_cnt_ff <= chunk_cnt_in;
   end

   // used counter, status and allocated page
   always_comb begin
      used_in = used_ff;
      if (pop_valid_ff) begin
         used_in = used_ff + CNT_W'(pop_sum);
      end else if (alloc_hit) begin
         used_in = used_ff + CNT_W'(1);
      end else if (free_hit) begin
         used_in = used_ff - CNT_W'(1);
      end
      status_in = status_ff;
      found_in = found_ff;
      if (cmd.setup) begin
         found_in = 1'b0;
         case (kind_ff)
            KIND_ALLOC: status_in = STAT_OUT_OF_MEMORY;
            KIND_FREE: begin
               if (range_err_ff) begin
                  status_in = STAT_OUT_OF_RANGE;
               end else if (align_err_ff) begin
                  status_in = STAT_MISALIGNED;
               end else begin
                  status_in = STAT_OK;
               end
            end
            default: status_in = STAT_OK;
         endcase
      end else if (alloc_hit) begin
         status_in = STAT_OK;
         found_in = 1'b1;
      end else if (free_miss) begin
         status_in = STAT_ALREADY_FREE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
      status_ff <= status_in;
      found_ff <= found_in;
      if (alloc_hit) begin
         alloc_idx_ff <= hit_page32[CNT_W-1:0];
      end
   end

   // clearing pass pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ptr_ff <= '0;
      end else if (cmd.clear) begin
         clr_ptr_ff <= clr_ptr_ff + WADDR_W'(1);
      end
   end

   // bitmap write port
   always_comb begin
      if (cmd.clear) begin
         ram_we = 1'b1;
         ram_waddr = clr_ptr_ff;
         ram_wdata = '0;
      end else begin
         ram_we = alloc_hit || free_hit || pop_valid_in;
         ram_waddr = chk_word_ff;
         ram_wdata = new_word;
      end
   end

   bpa_ram #(
      .WIDTH(WORD_BITS),
      .DEPTH(WORD_COUNT)
   ) u_bitmap (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(rd_ptr_ff),
      .rd_data(ram_rd_data)
   );

   // response formatting
   always_comb begin
      out_addr = found_ff ? (base_ff + (32'(alloc_idx_ff) << PAGE_SHIFT)) : '0;
      out_free = (pc_ff > used_ff) ? (pc_ff - used_ff) : '0;
      rsp_tdata_in = {3'b000, out_free, used_ff, status_ff, out_addr};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.resp_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
      if (cmd.resp_load) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata = rsp_tdata_ff;

   // status to controller
   always_comb begin
      stat.clear_last = clr_ptr_ff == WADDR_W'(WORD_COUNT - 1);
      stat.need_sweep = need_ff;
      stat.sweep_idle = !issuing_ff && !chk_valid_ff && !pop_valid_ff;
      stat.out_free = !rsp_tvalid_ff || rsp_tready;
   end

endmodule

[rtl/core/bitmap_page_allocator.sv]
// Accept to response: prep, setup, start, then a bitmap scan where needed (allocate reads
// words one per cycle, up to 64, until a free page; free one word; reserve the words spanned).
// One transaction in flight; the next is accepted in the cycle after the response is
// loaded, also while that response waits.
// Reset (synchronous): counters and config to defaults, then a clearing pass of
// one bitmap word per cycle before the first request is accepted.
module bitmap_page_allocator #(
   parameter int MAX_PAGES = 4096,
   parameter int PAGE_BYTES = 4096,
   parameter int WORD_BITS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   // configuration
   input  logic                            csr_we,
   input  logic [bpa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bpa_pkg::ADDR_W-1:0]      csr_wdata,
   // requests
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [63:0]                     req_tdata,  // address, end_address
   input  logic [bpa_pkg::KIND_W-1:0]      req_tuser,  // kind
   // responses
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [63:0]                     rsp_tdata   // page_address, status, used_pages,
                                                       // free_pages, zero pad
);

   import bpa_pkg::*;

   bpa_cmd_type  cmd;
   bpa_stat_type stat;

   bpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bpa_datapath #(
      .MAX_PAGES (MAX_PAGES),
      .PAGE_BYTES(PAGE_BYTES),
      .WORD_BITS (WORD_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

endmodule

[tb/sv/tb_top.sv]
module tb_top;
   import bpa_pkg::*;

   localparam int MAX_PAGES = 4096;
   localparam int PAGE_BYTES = 4096;
   localparam bit [63:0] OFFSET_MASK = 64'(PAGE_BYTES - 1);
   // the one kind code with no enum member: does nothing
   localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;

   typedef struct {
      logic [ADDR_W-1:0] page_address;
      status_type        status;
      logic [CNT_W-1:0]  used_pages;
      logic [CNT_W-1:0]  free_pages;
   } page_rsp_type;

   // Tracks the page bitmap and predicts one response per accepted request
   class page_alloc_tracker;
      bit                used_map [MAX_PAGES];
      int unsigned       used_count;
      logic [ADDR_W-1:0] phys_base;
      logic [CNT_W-1:0]  page_count;
      page_rsp_type      expected_rsp [$];
      int                errors;

      function new();
         used_count = 0;
         phys_base = '0;
         page_count = PAGE_COUNT_RESET;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [ADDR_W-1:0] value);
         if (index == CSR_PHYS_BASE)
            phys_base = value;
         else
            page_count = value[CNT_W-1:0];
      endfunction

      // a page count above the bitmap size acts as the bitmap size
      function int unsigned eff_pages();
         return (page_count > MAX_PAGES) ? MAX_PAGES : page_count;
      endfunction

      function bit [63:0] base_aligned();
         return {32'd0, phys_base} & ~OFFSET_MASK;
      endfunction

      function int pending();
         return expected_rsp.size();
      endfunction

      // address of a page that is likely in use, for frees that succeed
      function logic [ADDR_W-1:0] busy_page_address();
         int unsigned pc;
         int unsigned idx;
         pc = eff_pages();
         if (pc == 0)
            return $urandom;
         idx = 0;
         for (int k = 0; k < 8; k++) begin
            idx = $urandom_range(pc - 1);
            if (used_map[idx])
               break;
         end
         return 32'(base_aligned() + 64'(idx) * PAGE_BYTES);
      endfunction

      // predict the response of one accepted request and update the bitmap
      function void note_request(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr,
                                 logic [ADDR_W-1:0] end_addr);
         page_rsp_type r;
         bit [63:0]   base;
         bit [63:0]   ram_end;
         bit [63:0]   a64;
         bit [63:0]   e64;
         bit [63:0]   s;
         bit [63:0]   e;
         int unsigned pc;
         int unsigned idx;
         int unsigned first_pg;
         int unsigned last_pg;
         pc = eff_pages();
         base = base_aligned();
         ram_end = base + 64'(pc) * PAGE_BYTES;
         a64 = {32'd0, addr};
         e64 = {32'd0, end_addr};
         r.page_address = '0;
         r.status = STAT_OK;
         case (kind)
            KIND_ALLOC: begin
               // lowest free page wins; the address wraps at 32 bits
               r.status = STAT_OUT_OF_MEMORY;
               for (int unsigned i = 0; i < pc; i++) begin
                  if (!used_map[i]) begin
                     used_map[i] = 1'b1;
                     used_count++;
                     r.page_address = 32'(base + 64'(i) * PAGE_BYTES);
                     r.status = STAT_OK;
                     break;
                  end
               end
            end
            KIND_FREE: begin
               // range, then alignment, then already free
               if (a64 < base || a64 >= ram_end) begin
                  r.status = STAT_OUT_OF_RANGE;
               end else if ((a64 & OFFSET_MASK) != 0) begin
                  r.status = STAT_MISALIGNED;
               end else begin
                  idx = 32'((a64 - base) / PAGE_BYTES);
                  if (!used_map[idx]) begin
                     r.status = STAT_ALREADY_FREE;
                  end else begin
                     used_map[idx] = 1'b0;
                     used_count--;
                  end
               end
            end
            KIND_RESERVE: begin
               // empty range is judged before alignment; pages outside RAM are skipped
               if (e64 > a64) begin
                  s = a64 & ~OFFSET_MASK;
                  e = (e64 + OFFSET_MASK) & ~OFFSET_MASK;
                  if (s < base)
                     s = base;
                  if (e > ram_end)
                     e = ram_end;
                  if (e > s) begin
                     first_pg = 32'((s - base) / PAGE_BYTES);
                     last_pg = 32'((e - base) / PAGE_BYTES);
                     for (int unsigned i = first_pg; i < last_pg; i++) begin
                        if (!used_map[i]) begin
                           used_map[i] = 1'b1;
                           used_count++;
                        end
                     end
                  end
               end
            end
            default: ;
         endcase
         r.used_pages = 13'(used_count);
         r.free_pages = (pc > used_count) ? 13'(pc - used_count) : '0;
         expected_rsp.push_back(r);
      endfunction

      // compare one accepted response with the oldest prediction
      function void check_response(logic [63:0] data);
         page_rsp_type r;
         if (expected_rsp.size() == 0) begin
            $error("response 0x%h arrived with no request outstanding", data);
            errors++;
            return;
         end
         r = expected_rsp.pop_front();
         if (data[31:0] !== r.page_address) begin
            $error("page_address: expected 0x%h, got 0x%h", r.page_address, data[31:0]);
            errors++;
         end
         if (data[34:32] !== r.status) begin
            $error("status: expected %0d, got %0d", r.status, data[34:32]);
            errors++;
         end
         if (data[47:35] !== r.used_pages) begin
            $error("used_pages: expected %0d, got %0d", r.used_pages, data[47:35]);
            errors++;
         end
         if (data[60:48] !== r.free_pages) begin
            $error("free_pages: expected %0d, got %0d", r.free_pages, data[60:48]);
            errors++;
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [ADDR_W-1:0]      csr_wdata;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [63:0]            req_tdata;  // address, end_address
   logic [KIND_W-1:0]      req_tuser;  // kind
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [63:0]            rsp_tdata;  // page_address, status, used_pages, free_pages, pad

   page_alloc_tracker sb = new();

   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int rx_hold_cycles = 0;

   bitmap_page_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // safety net against a hung handshake
   initial begin
      #5000000;
      $display("TEST FAILED");
      $finish;
   end

   // response side: random back-pressure, or a long hold-off when asked
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rx_hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (rx_hold_cycles) @(posedge clock);
            rx_hold_cycles = 0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata);
   end

   // offer one request, wait until it is accepted, then maybe idle a while
   task automatic send_item(input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] addr,
                            input logic [ADDR_W-1:0] end_addr);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {end_addr, addr};
      do @(posedge clock); while (!req_tready);
      sb.note_request(kind, addr, end_addr);
      gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic stop_requests();
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // both registers, back to back; upper bits of the page count write are junk
   task automatic write_config(input logic [ADDR_W-1:0] base, input logic [CNT_W-1:0] count);
      logic [ADDR_W-1:0] junk;
      junk = $urandom;
      csr_we <= 1'b1;
      csr_index <= CSR_PHYS_BASE;
      csr_wdata <= base;
      @(posedge clock);
      csr_index <= CSR_PAGE_COUNT;
      csr_wdata <= {junk[ADDR_W-1:CNT_W], count};
      @(posedge clock);
      csr_we <= 1'b0;
      sb.write_reg(CSR_PHYS_BASE, base);
      sb.write_reg(CSR_PAGE_COUNT, count);
   endtask

   task automatic reconfigure(input logic [ADDR_W-1:0] base, input logic [CNT_W-1:0] count);
      stop_requests();
      wait_drained();
      write_config(base, count);
   endtask

   // mostly well-formed requests aimed at the managed range, some noise
   task automatic send_random_op();
      int unsigned      roll;
      int unsigned      sub;
      int unsigned      pc;
      logic [ADDR_W-1:0] base;
      logic [ADDR_W-1:0] a;
      logic [ADDR_W-1:0] e;
      roll = $urandom_range(99);
      sub = $urandom_range(9);
      pc = sb.eff_pages();
      base = 32'(sb.base_aligned());
      a = $urandom;
      e = $urandom;
      if (roll < 35) begin
         send_item(KIND_ALLOC, a, e);
      end else if (roll < 70) begin
         if (sub <= 5)
            a = sb.busy_page_address();
         else if (sub == 6)
            a = sb.busy_page_address() + $urandom_range(1, PAGE_BYTES - 1);
         else if (sub == 7)
            a = base + $urandom_range(0, pc + 8) * PAGE_BYTES;
         else if (sub == 8)
            a = base - $urandom_range(1, 4) * PAGE_BYTES;
         send_item(KIND_FREE, a, e);
      end else if (roll < 92) begin
         if (sub <= 6) begin
            a = base + $urandom_range(0, pc + 4) * PAGE_BYTES;
            if ($urandom_range(1))
               a = a + $urandom_range(0, PAGE_BYTES - 1);
            e = a + $urandom_range(0, 6 * PAGE_BYTES);
         end else if (sub == 7) begin
            e = a - $urandom_range(0, 3 * PAGE_BYTES);
         end
         send_item(KIND_RESERVE, a, e);
      end else begin
         send_item(KIND_NOP, a, e);
      end
   endtask

   task automatic run_random(input int count, input int hold_at, input int drain_at);
      for (int k = 0; k < count; k++) begin
         if (k == hold_at)
            rx_hold_cycles = 400;
         if (k == drain_at) begin
            stop_requests();
            wait_drained();
         end
         send_random_op();
      end
   endtask

   // stimulus
   initial begin
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= CSR_PHYS_BASE;
      csr_wdata <= '0;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= KIND_ALLOC;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      // the clearing pass runs before the first request is taken
      do @(posedge clock); while (!req_tready);

      // directed: reset configuration, 4096 pages at address 0
      send_item(KIND_ALLOC, 32'h0, 32'h0);
      send_item(KIND_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(KIND_FREE, 32'h0000_1000, 32'h0);
      send_item(KIND_FREE, 32'h0000_1000, 32'h0);
      send_item(KIND_FREE, 32'h0000_0801, 32'h0);
      send_item(KIND_FREE, 32'hFFFF_FFFF, 32'h0);
      send_item(KIND_FREE, 32'h0100_0000, 32'h0);
      send_item(KIND_RESERVE, 32'h0000_5000, 32'h0000_5000);
      send_item(KIND_RESERVE, 32'h0000_9000, 32'h0000_3000);
      send_item(KIND_RESERVE, 32'h0000_2FFF, 32'h0000_3001);
      send_item(KIND_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(KIND_RESERVE, 32'h00FF_F800, 32'hFFFF_FFFF);
      send_item(KIND_ALLOC, 32'h0, 32'h0);

      // shrink to 8 pages with a high page still used: counts floor at zero, high page unreachable
      reconfigure(32'h0, 13'd8);
      send_item(KIND_RESERVE, 32'h0, 32'hFFFF_FFFF);
      send_item(KIND_ALLOC, 32'h0, 32'h0);
      send_item(KIND_FREE, 32'h0000_8000, 32'h0);
      send_item(KIND_FREE, 32'h00FF_F000, 32'h0);
      send_item(KIND_FREE, 32'h0000_3000, 32'h0);
      send_item(KIND_ALLOC, 32'h0, 32'h0);

      // unaligned base near the top, oversized count: addresses wrap
      reconfigure(32'hFFFF_F7AB, 13'h1FFF);
      send_item(KIND_ALLOC, 32'h0, 32'h0);
      send_item(KIND_FREE, 32'h0000_7000, 32'h0);
      send_item(KIND_FREE, 32'hFFFF_F000, 32'h0);
      send_item(KIND_ALLOC, 32'h0, 32'h0);

      // no pages at all
      reconfigure(32'h0, 13'd0);
      send_item(KIND_ALLOC, 32'h0, 32'h0);
      send_item(KIND_RESERVE, 32'h0, 32'hFFFF_FFFF);
      send_item(KIND_FREE, 32'h0, 32'h0);

      // random: small RAM, slow receiver, long hold-off midway
      reconfigure(32'h8000_0000, 13'd64);
      tx_idle_pct = 25;
      rx_idle_pct = 70;
      run_random(300, 100, -1);

      // random: full RAM at zero, slow sender, one full drain midway
      reconfigure(32'h0, 13'd4096);
      tx_idle_pct = 70;
      rx_idle_pct = 25;
      run_random(250, -1, 120);

      // random: arbitrary base and count, no idling
      reconfigure($urandom, 13'($urandom_range(1, 200)));
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      run_random(150, -1, -1);

      // random: highest base, largest count
      reconfigure(32'hFFFF_FFFF, 13'h1FFF);
      run_random(125, -1, -1);

      stop_requests();
      wait_drained();
      repeat (100) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("%0d responses never arrived", sb.pending());
         sb.errors++;
      end
      if (sb.errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

[files.f]
rtl/core/bpa_pkg.sv
rtl/core/bpa_ram.sv
rtl/core/bpa_ctrl.sv
rtl/core/bpa_datapath.sv
rtl/core/bitmap_page_allocator.sv
tb/sv/tb_top.sv
